FILE: sv/sft_pkg.sv
// sft_pkg: shared constants, types and state codes of the syn flood tracker
// used by sft_entry_eval and syn_flood_tracker_unit
`default_nettype none

package sft_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam int ADDR_W     = 32;
    localparam int TIME_W     = 48;
    localparam int CNT_W      = 16;
    localparam int FLAGS_W    = 8;
    localparam int THR_W      = 16;
    localparam int WIN_W      = 16;
    localparam int EXP_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int FLAG_SYN_BIT = 1;
    localparam int FLAG_ACK_BIT = 4;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_SWEEP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYN_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE_TICKS  = 2'd3;

    localparam logic             RST_DETECT_ENABLE = 1'b1;
    localparam logic [THR_W-1:0] RST_SYN_THRESHOLD = 16'd50;
    localparam logic [WIN_W-1:0] RST_WINDOW_TICKS  = 16'd1000;
    localparam logic [EXP_W-1:0] RST_EXPIRE_TICKS  = 32'd60000;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] win_start;
        logic [CNT_W-1:0]  syn_cnt;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic hit;
        logic in_window;
        logic expired;
        logic older;
    } entry_eval_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

FILE: sv/sft_ram.sv
// sft_ram: generic single write port, single read port memory
// registered read data, no reset on the array; no dependencies
`default_nettype none

module sft_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 96,
    parameter int AW    = 6
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/sft_entry_eval.sv
// sft_entry_eval: shared compare unit applied to one table entry per cycle
// depends on sft_pkg
`default_nettype none

module sft_entry_eval
    import sft_pkg::*;
(
    input  wire entry_t            entry,
    input  wire logic [ADDR_W-1:0] src,
    input  wire logic [TIME_W-1:0] now,
    input  wire logic [WIN_W-1:0]  window_ticks,
    input  wire logic [EXP_W-1:0]  expire_ticks,
    input  wire logic [TIME_W-1:0] oldest_ws,
    input  wire logic              first,
    output entry_eval_t            eval
);

    logic [TIME_W-1:0] age;

    always_comb
    begin
        age            = now - entry.win_start;
        eval.hit       = (entry.addr == src);
        eval.in_window = (age < TIME_W'(window_ticks));
        eval.expired   = (entry.addr != '0) && (age > TIME_W'(expire_ticks));
        eval.older     = first || (entry.win_start < oldest_ws);
    end

endmodule

`default_nettype wire

FILE: sv/syn_flood_tracker_unit.sv
// syn_flood_tracker_unit: per-source syn flood tracker, top level
// holds config registers, scan sequencer and output register
// depends on sft_pkg, sft_ram, sft_entry_eval
//
// input channel in_valid/in_ready carries one word: command, src_addr,
// flags, now. output channel out_valid/out_ready returns exactly one word
// per input: is_syn, matched, flood, source_count.
// config is written through cfg_we/cfg_index/cfg_data while idle; the
// user must keep to that, the block itself does not enforce it.
// a packet that is a bare syn, and a sweep, read the table one entry per
// cycle through the single memory read port; a packet scan writes back in
// ST_UPDATE, a sweep goes to ST_FINISH; a matching packet stops early.
// non-syn packets and disabled items skip the scan and go to ST_FINISH.
// in_ready is high only while the sequencer is idle; a finished word
// waits in the output register, and the next input is still taken.
// a stalled receiver holds the next result in the sequencer until the
// output register frees up.
// after reset the table is cleared one entry per cycle, from entry 0 to
// LAST_IDX, with in_ready low; config writes are taken meanwhile.
`default_nettype none

module syn_flood_tracker_unit
    import sft_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  command,
    input  wire logic [ADDR_W-1:0]     src_addr,
    input  wire logic [FLAGS_W-1:0]    flags,
    input  wire logic [TIME_W-1:0]     now,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       is_syn,
    output logic                       matched,
    output logic                       flood,
    output logic [CNT_W-1:0]           source_count,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic             detect_enable_reg;
    logic [THR_W-1:0] syn_threshold_reg;
    logic [WIN_W-1:0] window_ticks_reg;
    logic [EXP_W-1:0] expire_ticks_reg;

    logic              cmd_reg, cmd_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [TIME_W-1:0] now_reg, now_next;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             issue_done_reg, issue_done_next;
    logic             data_vld_reg, data_vld_next;
    logic [IDX_W-1:0] data_idx_reg, data_idx_next;

    logic [TIME_W-1:0] oldest_ws_reg, oldest_ws_next;
    logic [IDX_W-1:0]  oldest_idx_reg, oldest_idx_next;
    logic [IDX_W-1:0]  tgt_idx_reg, tgt_idx_next;
    logic              matched_reg, matched_next;
    logic              inwin_reg, inwin_next;
    logic [TIME_W-1:0] hit_ws_reg, hit_ws_next;
    logic [CNT_W-1:0]  hit_cnt_reg, hit_cnt_next;

    logic             res_is_syn_reg, res_is_syn_next;
    logic             res_matched_reg, res_matched_next;
    logic             res_flood_reg, res_flood_next;
    logic [CNT_W-1:0] res_count_reg, res_count_next;

    logic             out_valid_reg, out_valid_next;
    logic             out_is_syn_reg, out_is_syn_next;
    logic             out_matched_reg, out_matched_next;
    logic             out_flood_reg, out_flood_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_rdata;
    logic             rd_issue;
    logic             out_load;

    logic             bare_syn;
    logic             short_path;
    logic             scan_last;
    logic             pkt_data;
    entry_eval_t      ev;

    logic [CNT_W-1:0]  inc_cnt;
    logic [CNT_W-1:0]  new_cnt;
    logic [TIME_W-1:0] new_ws;
    logic              new_flood;

    sft_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (ENTRY_W),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sft_entry_eval u_eval (
        .entry        (ram_rdata),
        .src          (src_reg),
        .now          (now_reg),
        .window_ticks (window_ticks_reg),
        .expire_ticks (expire_ticks_reg),
        .oldest_ws    (oldest_ws_reg),
        .first        (data_idx_reg == '0),
        .eval         (ev)
    );

    assign bare_syn   = flags[FLAG_SYN_BIT] && !flags[FLAG_ACK_BIT];
    assign short_path = !detect_enable_reg || ((command == CMD_PACKET) && !bare_syn);
    assign scan_last  = data_vld_reg && (data_idx_reg == LAST_IDX);
    assign pkt_data   = data_vld_reg && (cmd_reg == CMD_PACKET);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_enable_reg <= RST_DETECT_ENABLE;
            syn_threshold_reg <= RST_SYN_THRESHOLD;
            window_ticks_reg  <= RST_WINDOW_TICKS;
            expire_ticks_reg  <= RST_EXPIRE_TICKS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DETECT_ENABLE: detect_enable_reg <= cfg_data[0];
                CFG_SYN_THRESHOLD: syn_threshold_reg <= cfg_data[THR_W-1:0];
                CFG_WINDOW_TICKS:  window_ticks_reg  <= cfg_data[WIN_W-1:0];
                CFG_EXPIRE_TICKS:  expire_ticks_reg  <= cfg_data[EXP_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = short_path ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cmd_reg == CMD_SWEEP)
                begin
                    if (scan_last)
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else if (pkt_data && (ev.hit || scan_last))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // update arithmetic for the entry being written back
    always_comb
    begin
        inc_cnt = (hit_cnt_reg == CNT_MAX) ? hit_cnt_reg : hit_cnt_reg + CNT_W'(1);
        if (matched_reg && inwin_reg)
        begin
            new_cnt   = inc_cnt;
            new_ws    = hit_ws_reg;
            new_flood = (inc_cnt > syn_threshold_reg);
        end
        else
        begin
            new_cnt   = CNT_W'(1);
            new_ws    = now_reg;
            new_flood = 1'b0;
        end
    end

    // sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = data_idx_reg;
        ram_wdata = '0;
        ram_raddr = idx_reg;
        rd_issue  = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SCAN:
            begin
                rd_issue = !issue_done_reg;
                if (data_vld_reg && (cmd_reg == CMD_SWEEP) && ev.expired)
                begin
                    ram_we              = 1'b1;
                    ram_wdata.addr      = '0;
                    ram_wdata.win_start = ram_rdata.win_start;
                    ram_wdata.syn_cnt   = ram_rdata.syn_cnt;
                end
            end
            ST_UPDATE:
            begin
                ram_we              = 1'b1;
                ram_waddr           = tgt_idx_reg;
                ram_wdata.addr      = src_reg;
                ram_wdata.win_start = new_ws;
                ram_wdata.syn_cnt   = new_cnt;
            end
            ST_FINISH:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb
    begin
        cmd_next         = cmd_reg;
        src_next         = src_reg;
        now_next         = now_reg;
        idx_next         = idx_reg;
        issue_done_next  = issue_done_reg;
        data_vld_next    = rd_issue;
        data_idx_next    = idx_reg;
        oldest_ws_next   = oldest_ws_reg;
        oldest_idx_next  = oldest_idx_reg;
        tgt_idx_next     = tgt_idx_reg;
        matched_next     = matched_reg;
        inwin_next       = inwin_reg;
        hit_ws_next      = hit_ws_reg;
        hit_cnt_next     = hit_cnt_reg;
        res_is_syn_next  = res_is_syn_reg;
        res_matched_next = res_matched_reg;
        res_flood_next   = res_flood_reg;
        res_count_next   = res_count_reg;

        if ((state_reg == ST_CLEAR) && (idx_reg != LAST_IDX))
        begin
            idx_next = idx_reg + IDX_W'(1);
        end

        if (in_valid && in_ready)
        begin
            cmd_next         = command;
            src_next         = src_addr;
            now_next         = now;
            idx_next         = '0;
            issue_done_next  = 1'b0;
            matched_next     = 1'b0;
            res_is_syn_next  = 1'b0;
            res_matched_next = 1'b0;
            res_flood_next   = 1'b0;
            res_count_next   = '0;
        end

        if (rd_issue)
        begin
            if (idx_reg == LAST_IDX)
            begin
                issue_done_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end

        if ((state_reg == ST_SCAN) && pkt_data)
        begin
            if (ev.hit)
            begin
                matched_next = 1'b1;
                inwin_next   = ev.in_window;
                hit_ws_next  = ram_rdata.win_start;
                hit_cnt_next = ram_rdata.syn_cnt;
                tgt_idx_next = data_idx_reg;
            end
            else
            begin
                if (ev.older)
                begin
                    oldest_ws_next  = ram_rdata.win_start;
                    oldest_idx_next = data_idx_reg;
                end
                if (scan_last)
                begin
                    tgt_idx_next = ev.older ? data_idx_reg : oldest_idx_reg;
                end
            end
        end

        if (state_reg == ST_UPDATE)
        begin
            res_is_syn_next  = 1'b1;
            res_matched_next = matched_reg;
            res_flood_next   = new_flood;
            res_count_next   = new_cnt;
        end
    end

    // output register
    always_comb
    begin
        out_is_syn_next  = out_is_syn_reg;
        out_matched_next = out_matched_reg;
        out_flood_next   = out_flood_reg;
        out_count_next   = out_count_reg;
        if (out_load)
        begin
            out_valid_next   = 1'b1;
            out_is_syn_next  = res_is_syn_reg;
            out_matched_next = res_matched_reg;
            out_flood_next   = res_flood_reg;
            out_count_next   = res_count_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            idx_reg        <= '0;
            issue_done_reg <= 1'b1;
            data_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            issue_done_reg <= issue_done_next;
            data_vld_reg   <= data_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        src_reg         <= src_next;
        now_reg         <= now_next;
        data_idx_reg    <= data_idx_next;
        oldest_ws_reg   <= oldest_ws_next;
        oldest_idx_reg  <= oldest_idx_next;
        tgt_idx_reg     <= tgt_idx_next;
        matched_reg     <= matched_next;
        inwin_reg       <= inwin_next;
        hit_ws_reg      <= hit_ws_next;
        hit_cnt_reg     <= hit_cnt_next;
        res_is_syn_reg  <= res_is_syn_next;
        res_matched_reg <= res_matched_next;
        res_flood_reg   <= res_flood_next;
        res_count_reg   <= res_count_next;
        out_is_syn_reg  <= out_is_syn_next;
        out_matched_reg <= out_matched_next;
        out_flood_reg   <= out_flood_next;
        out_count_reg   <= out_count_next;
    end

    assign out_valid    = out_valid_reg;
    assign is_syn       = out_is_syn_reg;
    assign matched      = out_matched_reg;
    assign flood        = out_flood_reg;
    assign source_count = out_count_reg;

    a_scan_write_sweep_only: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == ST_SCAN)) |-> (cmd_reg == CMD_SWEEP))
        else $error("table written during a packet scan");

    a_clear_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid_reg)
        else $error("output word during table clear");

    a_update_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |=> (state_reg == ST_FINISH))
        else $error("update not followed by finish");

    a_hit_stops_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && pkt_data && ev.hit) |=> (state_reg == ST_UPDATE))
        else $error("packet scan did not stop on a hit");

    a_flood_implies_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_flood_reg) |-> (out_matched_reg && out_is_syn_reg
            && (out_count_reg != '0)))
        else $error("flood word without a matched syn");

endmodule

`default_nettype wire
